// File: rtl/core/hamc_pkg.sv
// ----------------------------------------------------------------------------
// hamc_pkg
// Types and Hamming(12,8) encode, syndrome and correction functions shared by
// the byte-stream codec.
// ----------------------------------------------------------------------------
package hamc_pkg;

  localparam int unsigned BURST_DEPTH = 3;
  localparam int unsigned COUNT_W     = 2;

  localparam logic [1:0] PHASE_EMPTY = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] P0_MASK = 8'h5B;
  localparam logic [7:0] P1_MASK = 8'h6D;
  localparam logic [7:0] P2_MASK = 8'h8E;
  localparam logic [7:0] P3_MASK = 8'hF0;

  localparam logic [11:0] S0_MASK = 12'h554;
  localparam logic [11:0] S1_MASK = 12'h664;
  localparam logic [11:0] S2_MASK = 12'h870;
  localparam logic [11:0] S3_MASK = 12'hF00;

  localparam int unsigned CW_BITS = 12;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] syndrome;
    logic       length_error;
    logic       out_last;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } load_t;

  function automatic logic [11:0] encode_word(input logic [7:0] d);
    logic [11:0] h;
    h      = '0;
    h[11:8] = d[7:4];
    h[6:4]  = d[3:1];
    h[2]    = d[0];
    h[0]    = ~^(d & P0_MASK);
    h[1]    = ~^(d & P1_MASK);
    h[3]    = ~^(d & P2_MASK);
    h[7]    = ~^(d & P3_MASK);
    return h;
  endfunction

  function automatic logic [3:0] syndrome_of(input logic [11:0] h);
    logic [3:0] s;
    s[0] = (~^(h & S0_MASK)) ^ h[0];
    s[1] = (~^(h & S1_MASK)) ^ h[1];
    s[2] = (~^(h & S2_MASK)) ^ h[3];
    s[3] = (~^(h & S3_MASK)) ^ h[7];
    return s;
  endfunction

  // Flip the position named by the syndrome; values past twelve flip nothing.
  function automatic result_t decode_word(input logic [11:0] h, input logic last);
    logic [3:0]  s;
    logic [11:0] c;
    result_t     r;
    s = syndrome_of(h);
    c = h;
    for (int i = 0; i < CW_BITS; i++) begin
      if (s == 4'(i + 1)) begin
        c[i] = ~h[i];
      end
    end
    r.out_byte     = {c[11:8], c[6:4], c[2]};
    r.syndrome     = s;
    r.length_error = 1'b0;
    r.out_last     = last;
    return r;
  endfunction

  function automatic result_t plain_result(input logic [7:0] b, input logic last);
    result_t r;
    r.out_byte     = b;
    r.syndrome     = 4'd0;
    r.length_error = 1'b0;
    r.out_last     = last;
    return r;
  endfunction

endpackage

// File: rtl/core/hamc_in_if.sv
// ----------------------------------------------------------------------------
// hamc_in_if
// Source byte channel: valid/ready handshake with byte and end-of-buffer mark.
// ----------------------------------------------------------------------------
interface hamc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/core/hamc_out_if.sv
// ----------------------------------------------------------------------------
// hamc_out_if
// Result byte channel: valid/ready handshake with byte, syndrome and status.
// ----------------------------------------------------------------------------
interface hamc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] syndrome;
  logic       length_error;
  logic       out_last;

  modport source (output valid, output out_byte, output syndrome,
                  output length_error, output out_last, input ready);
  modport sink   (input valid, input out_byte, input syndrome,
                  input length_error, input out_last, output ready);
endinterface

// File: rtl/core/hamc_out_buf.sv
// ----------------------------------------------------------------------------
// hamc_out_buf
// Three-entry result register. Loads a whole burst at once and drains it one
// transfer per cycle onto the result channel while that channel is ready.
// ----------------------------------------------------------------------------
module hamc_out_buf
  import hamc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  load_t             load,
  input  result_t           burst [BURST_DEPTH],
  output logic              can_load,
  hamc_out_if.source        dst
);

  logic [COUNT_W-1:0] count;
  result_t            entries [BURST_DEPTH];
  logic               xfer;

  assign dst.valid        = (count != '0);
  assign dst.out_byte     = entries[0].out_byte;
  assign dst.syndrome     = entries[0].syndrome;
  assign dst.length_error = entries[0].length_error;
  assign dst.out_last     = entries[0].out_last;

  assign xfer     = dst.valid & dst.ready;
  // Free now, or the last entry leaves in this cycle.
  assign can_load = (count == '0) || ((count == COUNT_W'(1)) && dst.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load.valid) begin
      count <= load.count;
    end else if (xfer) begin
      count <= count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      entries <= burst;
    end else if (xfer) begin
      // advance the queue toward the head
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        entries[i] <= entries[i + 1];
      end
    end
  end

endmodule

// File: rtl/core/hamming_12_8_byte_stream_codec.sv
// ----------------------------------------------------------------------------
// hamming_12_8_byte_stream_codec
// Byte-stream Hamming(12,8) single-error-correcting encoder and decoder.
// ----------------------------------------------------------------------------
// In encode mode (mode 0) every two source bytes become two 12-bit codewords
// sent as three bytes, low byte first; an odd final byte is paired with the
// codeword of zero. In decode mode (mode 1) every three bytes give two
// corrected data bytes with their syndromes, and a buffer that ends inside a
// group gives one result with length_error set. The result port moves one
// byte per cycle while the sink is ready, which sets the rate: encode takes
// pairs only as fast as their three results drain, decode one source byte
// per cycle. Each completed group is computed combinationally into a
// three-entry result register, and the next byte is taken while that burst
// drains. Write mode only while idle; a write drops any partial group.
// ----------------------------------------------------------------------------
module hamming_12_8_byte_stream_codec
  import hamc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  hamc_in_if.sink     src,
  hamc_out_if.source  dst
);

  logic        mode;
  logic [15:0] held_bytes;
  logic [1:0]  group_phase;

  logic        gen;
  logic        can_load;
  logic        xfer;
  load_t       load;
  result_t     burst [BURST_DEPTH];
  logic [23:0] packed_word;
  logic [23:0] dec_word;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;

  // Does this item close a group and produce results?
  always_comb begin
    if (mode == MODE_ENCODE) begin
      gen = (group_phase != PHASE_EMPTY) || src.in_last;
    end else begin
      gen = (group_phase == PHASE_TWO) || src.in_last;
    end
  end

  assign src.ready = can_load || !gen;
  assign xfer      = src.valid & src.ready;

  always_comb begin
    if (group_phase == PHASE_EMPTY) begin
      first_byte  = src.in_byte;
      second_byte = 8'h00;
    end else begin
      first_byte  = held_bytes[7:0];
      second_byte = src.in_byte;
    end
    packed_word = {encode_word(second_byte), encode_word(first_byte)};
    dec_word    = {src.in_byte, held_bytes};
  end

  always_comb begin
    load.valid = xfer & gen;
    load.count = COUNT_W'(1);
    burst[0]   = plain_result(8'h00, 1'b0);
    burst[1]   = plain_result(8'h00, 1'b0);
    burst[2]   = plain_result(8'h00, 1'b0);
    if (mode == MODE_ENCODE) begin
      load.count = COUNT_W'(3);
      burst[0]   = plain_result(packed_word[7:0], 1'b0);
      burst[1]   = plain_result(packed_word[15:8], 1'b0);
      burst[2]   = plain_result(packed_word[23:16], src.in_last);
    end else if (group_phase == PHASE_TWO) begin
      load.count = COUNT_W'(2);
      burst[0]   = decode_word(dec_word[11:0], 1'b0);
      burst[1]   = decode_word(dec_word[23:12], src.in_last);
    end else begin
      // short decode stream: report and drop the partial group
      burst[0].length_error = 1'b1;
      burst[0].out_last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      held_bytes  <= '0;
      group_phase <= PHASE_EMPTY;
    end else if (cfg_we) begin
      mode        <= cfg_wdata;
      held_bytes  <= '0;
      group_phase <= PHASE_EMPTY;
    end else if (xfer) begin
      if (gen) begin
        held_bytes  <= '0;
        group_phase <= PHASE_EMPTY;
      end else if (group_phase == PHASE_EMPTY) begin
        held_bytes  <= {8'h00, src.in_byte};
        group_phase <= PHASE_ONE;
      end else begin
        held_bytes  <= {src.in_byte, held_bytes[7:0]};
        group_phase <= PHASE_TWO;
      end
    end
  end

  hamc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst    (burst),
    .can_load (can_load),
    .dst      (dst)
  );

endmodule
